FILE: design/balanced_tree_floor_search_assert.svh
// Assertion macros for the balanced tree floor search block.
`ifndef BALANCED_TREE_FLOOR_SEARCH_ASSERT_SVH
`define BALANCED_TREE_FLOOR_SEARCH_ASSERT_SVH
// Implication checked every clock edge, off during reset.
`define BTFS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, off during reset.
`define BTFS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: design/btfs_pkg.sv
// Package: sizes, codes and the node word layout of the floor search block.
package btfs_pkg;
  localparam int unsigned MaxUnique  = 1024;
  localparam int unsigned TreeNodes  = 2047;
  localparam int unsigned StackDepth = 24;
  localparam int unsigned ScoreLimit = 1000000;

  localparam int unsigned UW = $clog2(MaxUnique);
  localparam int unsigned FW = $clog2(MaxUnique + 1);
  localparam int unsigned TW = $clog2(TreeNodes);
  localparam int unsigned SW = $clog2(StackDepth);
  localparam int unsigned SCW = $clog2(StackDepth + 1);
  localparam int unsigned VW = 20;
  localparam int unsigned CW = 16;
  // position arithmetic width, holds 2p+2 for any p < TreeNodes
  localparam int unsigned PW = TW + 2;

  typedef enum logic [1:0] {
    ModeLoad  = 2'd0,
    ModeBuild = 2'd1,
    ModeQuery = 2'd2,
    ModeClear = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StOrder   = 2'd1,
    StFull    = 2'd2,
    StMissing = 2'd3
  } status_e;

  // list entry: value, copies
  typedef struct packed {
    logic [VW-1:0] value;
    logic [CW-1:0] copies;
  } uentry_t;

  // tree node word
  typedef struct packed {
    logic          has_l;
    logic          has_r;
    logic [VW-1:0] value;
    logic [CW-1:0] copies;
  } tnode_t;

  // build range {lo, hi, pos}
  typedef struct packed {
    logic [FW-1:0] lo;
    logic [FW-1:0] hi;
    logic [TW-1:0] pos;
  } span_t;
endpackage

FILE: design/balanced_tree_floor_search.sv
// Balanced tree floor search block: load reads the last list entry, then writes; clear acts on acceptance.
// Build: pops each range off the stack, reads the middle list entry and writes the tree node.
// Query: one tree memory read per tree level walked.
// One word at a time; the next word is taken after the result is taken.
// Reset empties the list and drops the tree; memories keep stale contents.
module balanced_tree_floor_search import btfs_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    mode_i,
  input  logic [19:0]   score_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    status_o,
  output logic [10:0]   node_index_o,
  output logic [19:0]   node_value_o,
  output logic [15:0]   node_count_o,
  output logic [10:0]   unique_total_o
);
`include "balanced_tree_floor_search_assert.svh"
  logic u_we, t_we, s_we, busy;
  logic [UW-1:0] u_wa, u_ra;
  logic [TW-1:0] t_wa, t_ra;
  logic [SW-1:0] s_wa, s_ra;
  uentry_t u_wd, u_rd;
  tnode_t t_wd, t_rd;
  span_t s_wd, s_rd;

  btfs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .mode_i, .score_i,
    .out_valid_o, .out_ready_i, .status_o, .node_index_o, .node_value_o,
    .node_count_o, .unique_total_o,
    .u_we_o(u_we), .u_waddr_o(u_wa), .u_wdata_o(u_wd), .u_raddr_o(u_ra),
    .u_rdata_i(u_rd),
    .t_we_o(t_we), .t_waddr_o(t_wa), .t_wdata_o(t_wd), .t_raddr_o(t_ra),
    .t_rdata_i(t_rd),
    .s_we_o(s_we), .s_waddr_o(s_wa), .s_wdata_o(s_wd), .s_raddr_o(s_ra),
    .s_rdata_i(s_rd), .busy_o(busy)
  );

  btfs_ram #(.Width($bits(uentry_t)), .Depth(MaxUnique)) u_list (
    .clk_i, .we_i(u_we), .waddr_i(u_wa), .wdata_i(u_wd), .raddr_i(u_ra),
    .rdata_o(u_rd));
  btfs_ram #(.Width($bits(tnode_t)), .Depth(TreeNodes)) u_tree (
    .clk_i, .we_i(t_we), .waddr_i(t_wa), .wdata_i(t_wd), .raddr_i(t_ra),
    .rdata_o(t_rd));
  btfs_ram #(.Width($bits(span_t)), .Depth(StackDepth)) u_stack (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_ra),
    .rdata_o(s_rd));

  `BTFS_ASSERT_IMP(a_ready_idle, in_ready_o, !busy && !out_valid_o,
                   "ready while busy")
  `BTFS_ASSERT_IMP(a_fill_max, 1'b1, unique_total_o <= 11'(MaxUnique),
                   "fill beyond list size")
  `BTFS_ASSERT_NXT(a_busy_novalid, busy && !out_valid_o, !in_ready_o || !busy,
                   "word taken during walk")
endmodule

FILE: design/btfs_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module btfs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: design/btfs_ctrl.sv
// Sequencer: load, build walk over the range stack, floor query descent.
module btfs_ctrl import btfs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      mode_i,
  input  logic [VW-1:0]   score_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      status_o,
  output logic [TW-1:0]   node_index_o,
  output logic [VW-1:0]   node_value_o,
  output logic [CW-1:0]   node_count_o,
  output logic [FW-1:0]   unique_total_o,
  // list memory
  output logic            u_we_o,
  output logic [UW-1:0]   u_waddr_o,
  output uentry_t         u_wdata_o,
  output logic [UW-1:0]   u_raddr_o,
  input  uentry_t         u_rdata_i,
  // tree memory
  output logic            t_we_o,
  output logic [TW-1:0]   t_waddr_o,
  output tnode_t          t_wdata_o,
  output logic [TW-1:0]   t_raddr_o,
  input  tnode_t          t_rdata_i,
  // stack memory
  output logic            s_we_o,
  output logic [SW-1:0]   s_waddr_o,
  output span_t           s_wdata_o,
  output logic [SW-1:0]   s_raddr_o,
  input  span_t           s_rdata_i,
  output logic            busy_o
);
  typedef enum logic [7:0] {
    SIdle  = 8'b00000001,
    SLoad  = 8'b00000010,
    SPop   = 8'b00000100,
    SSpan  = 8'b00001000,
    SMid   = 8'b00010000,
    SNode  = 8'b00100000,
    SQry   = 8'b01000000,
    SOut   = 8'b10000000
  } state_e;

  state_e          state_q, state_d;
  logic [FW-1:0]   fill_q, fill_d;
  logic            ready_q, ready_d;
  logic [VW-1:0]   tgt_q, tgt_d;
  logic [SCW-1:0]  sp_q, sp_d;
  span_t           span_q, span_d;
  logic [FW-1:0]   mid_q, mid_d;
  logic [TW-1:0]   cur_q, cur_d;
  logic            found_q, found_d;
  logic [TW-1:0]   best_q, best_d;
  logic [VW-1:0]   bval_q, bval_d;
  logic [CW-1:0]   bcnt_q, bcnt_d;
  logic            pushr_q, pushr_d;
  logic            vld_q, vld_d;
  logic [1:0]      st_q, st_d;
  logic [TW-1:0]   oidx_q, oidx_d;
  logic [VW-1:0]   oval_q, oval_d;
  logic [CW-1:0]   ocnt_q, ocnt_d;

  logic [VW-1:0]   clamped;
  logic [PW-1:0]   lpos, rpos, qlpos, qrpos;
  logic [FW:0]     midsum;
  logic            left_ok, right_ok;

  assign clamped = (score_i > VW'(ScoreLimit)) ? VW'(ScoreLimit) : score_i;
  assign in_ready_o = (state_q == SIdle) && !vld_q;
  assign out_valid_o = vld_q;
  assign status_o = st_q;
  assign node_index_o = oidx_q;
  assign node_value_o = oval_q;
  assign node_count_o = ocnt_q;
  assign unique_total_o = fill_q;
  assign busy_o = state_q != SIdle;

  assign midsum = {1'b0, span_q.lo} + {1'b0, span_q.hi};
  assign lpos = PW'({span_q.pos, 1'b1});
  assign rpos = PW'({span_q.pos, 1'b0}) + PW'(2);
  assign qlpos = PW'({cur_q, 1'b1});
  assign qrpos = PW'({cur_q, 1'b0}) + PW'(2);
  assign left_ok = (span_q.lo < mid_q) && (lpos < PW'(TreeNodes))
                   && (sp_q < SCW'(StackDepth));
  assign right_ok = (mid_q + FW'(1) < span_q.hi) && (rpos < PW'(TreeNodes))
                    && ((sp_q + SCW'(left_ok)) < SCW'(StackDepth));

  always_comb begin
    state_d = state_q; fill_d = fill_q; ready_d = ready_q;
    tgt_d = tgt_q; sp_d = sp_q; span_d = span_q; mid_d = mid_q; cur_d = cur_q;
    found_d = found_q; best_d = best_q; bval_d = bval_q; bcnt_d = bcnt_q;
    pushr_d = pushr_q; vld_d = vld_q; st_d = st_q; oidx_d = oidx_q;
    oval_d = oval_q; ocnt_d = ocnt_q;
    u_we_o = 1'b0; u_waddr_o = '0; u_wdata_o = '0;
    u_raddr_o = UW'(fill_q - FW'(1));
    t_we_o = 1'b0; t_waddr_o = span_q.pos; t_wdata_o = '0; t_raddr_o = cur_q;
    s_we_o = 1'b0; s_waddr_o = sp_q[SW-1:0]; s_wdata_o = '0;
    s_raddr_o = SW'(sp_q - SCW'(1));
    if (vld_q && out_ready_i) vld_d = 1'b0;
    case (state_q)
      SIdle: begin
        if (in_valid_i && in_ready_o) begin
          tgt_d = clamped;
          oidx_d = '0; oval_d = '0; ocnt_d = '0; st_d = StOk;
          case (mode_e'(mode_i))
            ModeLoad: state_d = SLoad;
            ModeBuild: begin
              if (fill_q == '0) begin
                ready_d = 1'b0; st_d = StMissing; vld_d = 1'b1;
              end else begin
                s_we_o = 1'b1; s_waddr_o = '0;
                s_wdata_o = '{lo: '0, hi: fill_q, pos: '0};
                sp_d = SCW'(1); state_d = SPop;
              end
            end
            ModeQuery: begin
              if (!ready_q) begin
                st_d = StMissing; vld_d = 1'b1;
              end else begin
                cur_d = '0; t_raddr_o = '0; found_d = 1'b0; state_d = SQry;
              end
            end
            default: begin
              fill_d = '0; ready_d = 1'b0; vld_d = 1'b1;
            end
          endcase
        end
      end
      SLoad: begin
        // last entry read data is available now
        if (fill_q != '0 && tgt_q < u_rdata_i.value) begin
          st_d = StOrder;
        end else if (fill_q != '0 && tgt_q == u_rdata_i.value) begin
          u_we_o = 1'b1; u_waddr_o = UW'(fill_q - FW'(1));
          u_wdata_o.value = tgt_q;
          u_wdata_o.copies = (&u_rdata_i.copies) ? u_rdata_i.copies
                                                 : u_rdata_i.copies + CW'(1);
          ready_d = 1'b0;
        end else if (fill_q >= FW'(MaxUnique)) begin
          st_d = StFull;
        end else begin
          u_we_o = 1'b1; u_waddr_o = UW'(fill_q);
          u_wdata_o.value = tgt_q; u_wdata_o.copies = CW'(1);
          fill_d = fill_q + FW'(1); ready_d = 1'b0;
        end
        vld_d = 1'b1; state_d = SIdle;
      end
      SPop: begin
        // stack read issued by default address
        if (sp_q == '0) begin
          ready_d = 1'b1; st_d = StOk; vld_d = 1'b1; state_d = SIdle;
        end else begin
          sp_d = sp_q - SCW'(1); state_d = SSpan;
        end
      end
      SSpan: begin
        span_d = s_rdata_i;
        state_d = SMid;
      end
      SMid: begin
        // ranges pushed are always nonempty and in bounds
        mid_d = midsum[FW:1];
        u_raddr_o = UW'(midsum[FW:1]);
        pushr_d = 1'b0;
        state_d = SNode;
      end
      SNode: begin
        if (!pushr_q) begin
          t_we_o = 1'b1; t_waddr_o = span_q.pos;
          t_wdata_o = '{has_l: left_ok, has_r: right_ok,
                        value: u_rdata_i.value, copies: u_rdata_i.copies};
          if (left_ok) begin
            s_we_o = 1'b1; s_waddr_o = sp_q[SW-1:0];
            s_wdata_o = '{lo: span_q.lo, hi: mid_q, pos: TW'(lpos)};
            sp_d = sp_q + SCW'(1);
          end
          if (right_ok) begin
            pushr_d = 1'b1;
            span_d.lo = mid_q + FW'(1); span_d.pos = TW'(rpos);
          end else begin
            state_d = SPop;
          end
        end else begin
          s_we_o = 1'b1; s_waddr_o = sp_q[SW-1:0]; s_wdata_o = span_q;
          sp_d = sp_q + SCW'(1); state_d = SPop;
        end
      end
      SQry: begin
        state_d = SOut;
      end
      SOut: begin
        // node word of cur_q is on the read port
        t_raddr_o = cur_q;
        if (t_rdata_i.value == tgt_q) begin
          st_d = StOk; oidx_d = cur_q; oval_d = t_rdata_i.value;
          ocnt_d = t_rdata_i.copies; vld_d = 1'b1; state_d = SIdle;
        end else if (t_rdata_i.value > tgt_q) begin
          if (t_rdata_i.has_l) begin
            cur_d = TW'(qlpos); t_raddr_o = TW'(qlpos); state_d = SQry;
          end else begin
            st_d = found_q ? StOk : StMissing;
            oidx_d = found_q ? best_q : '0;
            oval_d = found_q ? bval_q : '0;
            ocnt_d = found_q ? bcnt_q : '0;
            vld_d = 1'b1; state_d = SIdle;
          end
        end else begin
          if (t_rdata_i.has_r) begin
            found_d = 1'b1; best_d = cur_q; bval_d = t_rdata_i.value;
            bcnt_d = t_rdata_i.copies;
            cur_d = TW'(qrpos); t_raddr_o = TW'(qrpos); state_d = SQry;
          end else begin
            st_d = StOk; oidx_d = cur_q; oval_d = t_rdata_i.value;
            ocnt_d = t_rdata_i.copies; vld_d = 1'b1; state_d = SIdle;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // SQry: tree read was issued the cycle before; SQry waits, then SOut compares
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; fill_q <= '0; ready_q <= 1'b0; vld_q <= 1'b0;
      sp_q <= '0; pushr_q <= 1'b0; found_q <= 1'b0;
    end else begin
      state_q <= state_d; fill_q <= fill_d; ready_q <= ready_d; vld_q <= vld_d;
      sp_q <= sp_d; pushr_q <= pushr_d; found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q <= tgt_d; span_q <= span_d; mid_q <= mid_d;
    cur_q <= cur_d; best_q <= best_d; bval_q <= bval_d; bcnt_q <= bcnt_d;
    st_q <= st_d; oidx_q <= oidx_d; oval_q <= oval_d; ocnt_q <= ocnt_d;
  end
endmodule

FILE: tb/balanced_tree_floor_search_checker.sv
// Checker for the floor search block: predicts each result word and compares it.
`timescale 1ns / 1ps

module balanced_tree_floor_search_checker import btfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  mode_i,
  input  logic [19:0] score_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic [10:0] node_index_i,
  input  logic [19:0] node_value_i,
  input  logic [15:0] node_count_i,
  input  logic [10:0] unique_total_i,
  output int          pending_o,
  output int          fail_count_o
);

  typedef struct packed {
    status_e     status;
    logic [10:0] index;
    logic [19:0] value;
    logic [15:0] count;
    logic [10:0] total;
  } result_t;

  // shadow copy of the list and the tree
  logic [19:0] list_val[MaxUnique];
  logic [15:0] list_cnt[MaxUnique];
  int unsigned list_fill;
  logic [19:0] node_val[TreeNodes];
  logic [15:0] node_cnt[TreeNodes];
  bit          left_ok[TreeNodes];
  bit          right_ok[TreeNodes];
  bit          built;

  result_t expected_q[$];
  int      fails;

  assign pending_o    = expected_q.size();
  assign fail_count_o = fails;

  // load one score into the sorted list
  function automatic status_e load_score(logic [19:0] s);
    if (list_fill > 0) begin
      if (s < list_val[list_fill-1]) return StOrder;
      if (s == list_val[list_fill-1]) begin
        if (list_cnt[list_fill-1] != 16'hFFFF) list_cnt[list_fill-1]++;
        built = 0;
        return StOk;
      end
    end
    if (list_fill >= MaxUnique) return StFull;
    list_val[list_fill] = s;
    list_cnt[list_fill] = 16'd1;
    list_fill++;
    built = 0;
    return StOk;
  endfunction

  // lay the list out in heap order, one range per stack entry
  function automatic status_e build_tree();
    int unsigned lo_s[StackDepth];
    int unsigned hi_s[StackDepth];
    int unsigned pos_s[StackDepth];
    int unsigned sp, lo, hi, p, mid;
    if (list_fill == 0) begin
      built = 0;
      return StMissing;
    end
    sp = 1;
    lo_s[0] = 0; hi_s[0] = list_fill; pos_s[0] = 0;
    while (sp > 0) begin
      sp--;
      lo = lo_s[sp]; hi = hi_s[sp]; p = pos_s[sp];
      if (p >= TreeNodes || lo >= hi || hi > list_fill) continue;
      mid = (lo + hi) >> 1;
      node_val[p] = list_val[mid];
      node_cnt[p] = list_cnt[mid];
      left_ok[p]  = 0;
      right_ok[p] = 0;
      if (lo < mid && 2*p+1 < TreeNodes && sp < StackDepth) begin
        left_ok[p] = 1;
        lo_s[sp] = lo; hi_s[sp] = mid; pos_s[sp] = 2*p+1;
        sp++;
      end
      if (mid + 1 < hi && 2*p+2 < TreeNodes && sp < StackDepth) begin
        right_ok[p] = 1;
        lo_s[sp] = mid + 1; hi_s[sp] = hi; pos_s[sp] = 2*p+2;
        sp++;
      end
    end
    built = 1;
    return StOk;
  endfunction

  // expected result word for one accepted input word
  function automatic result_t predict_result(mode_e m, logic [19:0] raw);
    result_t     r;
    logic [19:0] s;
    int unsigned cur, best;
    bit          found, done;
    s = (raw > ScoreLimit) ? 20'(ScoreLimit) : raw;
    r = '0;
    case (m)
      ModeLoad:  r.status = load_score(s);
      ModeBuild: r.status = build_tree();
      ModeQuery: begin
        r.status = StMissing;
        if (built) begin
          cur = 0; best = 0; found = 0; done = 0;
          while (!done && cur < TreeNodes) begin
            if (node_val[cur] == s) begin
              found = 1; best = cur; done = 1;
            end else if (node_val[cur] > s) begin
              if (!left_ok[cur]) done = 1;
              else cur = 2*cur + 1;
            end else begin
              found = 1; best = cur;
              if (!right_ok[cur]) done = 1;
              else cur = 2*cur + 2;
            end
          end
          if (found) begin
            r.status = StOk;
            r.index  = 11'(best);
            r.value  = node_val[best];
            r.count  = node_cnt[best];
          end
        end
      end
      default: begin
        list_fill = 0;
        built = 0;
        r.status = StOk;
      end
    endcase
    r.total = 11'(list_fill);
    return r;
  endfunction

  // watch both channels; result side first, the block holds one word at a time
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      list_fill = 0;
      built = 0;
      fails = 0;
      expected_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = {status_e'(status_i), node_index_i, node_value_i, node_count_i,
               unique_total_i};
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("ERROR: result word with nothing expected: %h", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10)
              $display({"ERROR: status %0d/%0d index %0d/%0d value %0d/%0d",
                        " count %0d/%0d total %0d/%0d (exp/act)"},
                       want.status, got.status, want.index, got.index, want.value,
                       got.value, want.count, got.count, want.total, got.total);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_q.insert(expected_q.size(), predict_result(mode_e'(mode_i), score_i));
    end
  end

endmodule

FILE: tb/balanced_tree_floor_search_tb.sv
// Testbench top for the floor search block: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module balanced_tree_floor_search_tb import btfs_pkg::*;;

  logic        clk, rst_n;
  logic        in_valid, in_ready, out_valid, out_ready;
  logic [1:0]  mode;
  logic [19:0] score;
  logic [1:0]  status;
  logic [10:0] node_index, unique_total;
  logic [19:0] node_value;
  logic [15:0] node_count;
  int          pending, fail_count;

  int idle_pct, stall_pct, hold_cycles, words_sent;

  balanced_tree_floor_search dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .mode_i(mode), .score_i(score),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .node_index_o(node_index), .node_value_o(node_value),
    .node_count_o(node_count), .unique_total_o(unique_total)
  );

  balanced_tree_floor_search_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .mode_i(mode), .score_i(score),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .status_i(status),
    .node_index_i(node_index), .node_value_i(node_value), .node_count_i(node_count),
    .unique_total_i(unique_total), .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // offer one word, with an optional idle gap first; valid stays up afterwards
  task automatic send_word(mode_e m, logic [19:0] s);
    bit rdy;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1;
    mode     <= m;
    score    <= s;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    words_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // random run: optional clear, mostly ascending loads with repeats, usually a build, queries
  task automatic random_run(int unsigned max_len);
    logic [19:0] last, s;
    int unsigned len;
    last = 0;
    if ($urandom_range(3) == 0) send_word(ModeClear, 20'($urandom));
    len = $urandom_range(1, max_len);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0:       s = (last > 0) ? last - 20'($urandom_range(1, 9)) : 0;
        1, 2:    s = last;
        9:       s = 20'($urandom);
        default: s = last + 20'($urandom_range(1, 40000));
      endcase
      send_word(ModeLoad, s);
      if (s >= last) last = s;
    end
    if ($urandom_range(9) != 0) send_word(ModeBuild, 20'($urandom));
    repeat ($urandom_range(3, 12)) begin
      case ($urandom_range(4))
        0:       s = 20'($urandom);
        1:       s = last;
        2:       s = 0;
        default: s = 20'($urandom_range(0, last + 1000));
      endcase
      send_word(ModeQuery, s);
    end
    // occasional noise word
    if ($urandom_range(4) == 0) send_word(mode_e'($urandom_range(3)), 20'($urandom));
  endtask

  initial begin
    rst_n = 0; in_valid = 0; mode = ModeLoad; score = 0;
    idle_pct = 0; stall_pct = 0; hold_cycles = 0; words_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed corners
    send_word(ModeQuery, 20'd5);
    send_word(ModeBuild, 20'd0);
    send_word(ModeLoad, 20'd0);
    send_word(ModeLoad, 20'd0);
    send_word(ModeLoad, 20'd5);
    send_word(ModeLoad, 20'd3);
    send_word(ModeLoad, 20'hFFFFF);
    send_word(ModeBuild, 20'd0);
    send_word(ModeQuery, 20'd0);
    send_word(ModeQuery, 20'd4);
    send_word(ModeQuery, 20'd5);
    send_word(ModeQuery, 20'd999999);
    send_word(ModeQuery, 20'hFFFFF);
    send_word(ModeLoad, 20'd2);
    send_word(ModeLoad, 20'hFFFFF);
    send_word(ModeQuery, 20'd5);
    send_word(ModeClear, 20'hFFFFF);
    send_word(ModeQuery, 20'd0);
    send_word(ModeLoad, 20'd7);
    send_word(ModeBuild, 20'd0);
    send_word(ModeQuery, 20'd6);
    send_word(ModeQuery, 20'd7);

    // fill the list to the brim, then overflow it
    send_word(ModeClear, 20'd0);
    for (int i = 0; i < MaxUnique; i++) send_word(ModeLoad, 20'(i * 977));
    send_word(ModeLoad, 20'd999998);
    send_word(ModeLoad, 20'((MaxUnique - 1) * 977));
    send_word(ModeBuild, 20'd0);
    repeat (20) send_word(ModeQuery, 20'($urandom_range(0, ScoreLimit)));
    send_word(ModeQuery, 20'd977);

    // pause until every result has come back
    drain_results();

    // random runs under four flow-control mixes
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 59 : (ph == 3) ? 32 : 0;
      stall_pct = (ph == 2) ? 59 : (ph == 3) ? 32 : 0;
      // receiver holds off while the sender keeps offering
      if (ph == 2) hold_cycles = 400;
      while (words_sent < 1080 + 68 * (ph + 1))
        random_run(($urandom_range(19) == 0) ? 120 : 16);
      drain_results();
    end

    drain_results();
    repeat (60) @(posedge clk);
    $display("Covered %0d input words: corners, a full list with overflow, and",
             words_sent);
    $display("random load/build/query runs under idle, stall and hold-off mixes.");
    if (fail_count == 0) begin
      $display("PASS balanced_tree_floor_search");
    end else begin
      $display("FAIL balanced_tree_floor_search");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL balanced_tree_floor_search");
    $finish;
  end

endmodule

FILE: balanced_tree_floor_search.f
+incdir+design
design/btfs_pkg.sv
design/btfs_ram.sv
design/btfs_ctrl.sv
design/balanced_tree_floor_search.sv
tb/balanced_tree_floor_search_checker.sv
tb/balanced_tree_floor_search_tb.sv
